// File: rtl/smau_pkg.sv
// ----------------------------------------------------------------------------
// Sprite motion unit package
// Shared types, codes and helper functions for the sprite motion and
// animation unit.
// ----------------------------------------------------------------------------
package smau_pkg;

  // Inset of the sprite box used by the collide command.
  localparam int Border = 0;

  // Command codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_PLACE   = 3'd0,
    MODE_MOVE    = 3'd1,
    MODE_NEXT    = 3'd2,
    MODE_PREV    = 3'd3,
    MODE_SET     = 3'd4,
    MODE_DIE     = 3'd5,
    MODE_COLLIDE = 3'd6
  } mode_t;

  // Life state codes as reported on the result channel.
  typedef enum logic [1:0] {
    LIFE_ALIVE = 2'd0,
    LIFE_DYING = 2'd1,
    LIFE_DEAD  = 2'd2
  } life_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_VIEW_LEFT     = 3'd0,
    REG_VIEW_TOP      = 3'd1,
    REG_VIEW_RIGHT    = 3'd2,
    REG_VIEW_BOTTOM   = 3'd3,
    REG_SPRITE_WIDTH  = 3'd4,
    REG_SPRITE_HEIGHT = 3'd5,
    REG_NORMAL_FRAMES = 3'd6,
    REG_DYING_FRAMES  = 3'd7
  } cfg_reg_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] view_left;
    logic [15:0] view_top;
    logic [15:0] view_right;
    logic [15:0] view_bottom;
    logic [7:0]  sprite_width;
    logic [7:0]  sprite_height;
    logic [7:0]  normal_frames;
    logic [7:0]  dying_frames;
  } cfg_t;

  // One command transaction.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] place_x;
    logic [15:0] place_y;
    logic [15:0] step_dx;
    logic [15:0] step_dy;
    logic [8:0]  frame_number;
    logic [15:0] other_left;
    logic [15:0] other_top;
    logic [15:0] other_right;
    logic [15:0] other_bottom;
    logic        other_alive;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [8:0]  frame_index;
    logic [1:0]  life_state;
    logic        collided;
  } res_t;

  // Position and velocity of one axis after a move.
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] vel;
  } axis_t;

  // Step one axis, then bounce off [lo, hi) for a sprite of extent ext.
  function automatic axis_t axis_move(logic [15:0] pos, logic [15:0] vel,
                                      logic [15:0] step, logic [15:0] lo,
                                      logic [15:0] hi, logic [7:0] ext);
    logic [15:0]        sum;
    logic signed [17:0] far_edge;
    logic               bounce;
    axis_t              r;
    sum      = pos + step;
    far_edge = $signed({{2{sum[15]}}, sum}) + $signed({10'd0, ext});
    bounce   = (far_edge >= $signed({{2{hi[15]}}, hi})) ||
               ($signed(sum) < $signed(lo));
    r.vel    = bounce ? (16'd0 - vel) : vel;
    r.pos    = bounce ? (sum + r.vel) : sum;
    return r;
  endfunction

endpackage

// File: rtl/smau_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sprite motion unit configuration registers
// Write-only register file for the viewport, sprite size and frame counts.
// ----------------------------------------------------------------------------
module smau_cfg_regs import smau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Register writes, selected by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_left     <= 16'd0;
      cfg.view_top      <= 16'd0;
      cfg.view_right    <= 16'd320;
      cfg.view_bottom   <= 16'd240;
      cfg.sprite_width  <= 8'd16;
      cfg.sprite_height <= 8'd16;
      cfg.normal_frames <= 8'd1;
      cfg.dying_frames  <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_LEFT:     cfg.view_left     <= cfg_data;
        REG_VIEW_TOP:      cfg.view_top      <= cfg_data;
        REG_VIEW_RIGHT:    cfg.view_right    <= cfg_data;
        REG_VIEW_BOTTOM:   cfg.view_bottom   <= cfg_data;
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[7:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[7:0];
        REG_NORMAL_FRAMES: cfg.normal_frames <= cfg_data[7:0];
        REG_DYING_FRAMES:  cfg.dying_frames  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/smau_core.sv
// ----------------------------------------------------------------------------
// Sprite motion unit execution core
// Sprite state registers and the combinational command logic that updates
// them and forms the result of each command.
// ----------------------------------------------------------------------------
module smau_core import smau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic exec_en,
  input  cmd_t cmd,
  output res_t res
);

  logic [15:0] x_position, x_position_next;
  logic [15:0] y_position, y_position_next;
  logic [15:0] x_velocity, x_velocity_next;
  logic [15:0] y_velocity, y_velocity_next;
  logic [8:0]  current_frame, current_frame_next;
  life_t       life, life_next;

  axis_t              x_axis, y_axis;
  logic [9:0]         frame_inc;
  logic [9:0]         frame_end;
  logic signed [17:0] box_x0, box_x1, box_y0, box_y1;
  logic               hit;

  // Bounce logic for both axes; y does not depend on x.
  assign x_axis = axis_move(x_position, x_velocity, cmd.step_dx, cfg.view_left,
                            cfg.view_right, cfg.sprite_width);
  assign y_axis = axis_move(y_position, y_velocity, cmd.step_dy, cfg.view_top,
                            cfg.view_bottom, cfg.sprite_height);

  // Frame counter arithmetic.
  assign frame_inc = {1'b0, current_frame} + 10'd1;
  assign frame_end = {2'b00, cfg.normal_frames} + {2'b00, cfg.dying_frames};

  // Inset own box and strict overlap test against the other rectangle.
  assign box_x0 = $signed({{2{x_position[15]}}, x_position}) + 18'(Border);
  assign box_y0 = $signed({{2{y_position[15]}}, y_position}) + 18'(Border);
  assign box_x1 = $signed({{2{x_position[15]}}, x_position})
                + $signed({10'd0, cfg.sprite_width}) - 18'(Border);
  assign box_y1 = $signed({{2{y_position[15]}}, y_position})
                + $signed({10'd0, cfg.sprite_height}) - 18'(Border);
  assign hit = cmd.other_alive
             && ($signed({{2{cmd.other_left[15]}}, cmd.other_left}) < box_x1)
             && ($signed({{2{cmd.other_right[15]}}, cmd.other_right}) > box_x0)
             && ($signed({{2{cmd.other_top[15]}}, cmd.other_top}) < box_y1)
             && ($signed({{2{cmd.other_bottom[15]}}, cmd.other_bottom}) > box_y0);

  // Next-state selection by command.
  always_comb begin
    x_position_next    = x_position;
    y_position_next    = y_position;
    x_velocity_next    = x_velocity;
    y_velocity_next    = y_velocity;
    current_frame_next = current_frame;
    life_next          = life;
    unique case (mode_t'(cmd.mode))
      MODE_PLACE: begin
        x_position_next    = cmd.place_x;
        y_position_next    = cmd.place_y;
        x_velocity_next    = cmd.step_dx;
        y_velocity_next    = cmd.step_dy;
        current_frame_next = 9'd0;
        life_next          = LIFE_ALIVE;
      end
      MODE_MOVE: begin
        x_position_next = x_axis.pos;
        x_velocity_next = x_axis.vel;
        y_position_next = y_axis.pos;
        y_velocity_next = y_axis.vel;
      end
      MODE_NEXT: begin
        unique case (life)
          LIFE_ALIVE: begin
            current_frame_next = (frame_inc >= {2'b00, cfg.normal_frames}) ?
                                 9'd0 : frame_inc[8:0];
          end
          LIFE_DYING: begin
            current_frame_next = frame_inc[8:0];
            if (frame_inc >= frame_end) begin
              life_next = LIFE_DEAD;
            end
          end
          default: ;
        endcase
      end
      MODE_PREV: begin
        current_frame_next = (current_frame == 9'd0) ?
                             ({1'b0, cfg.normal_frames} - 9'd1) :
                             (current_frame - 9'd1);
      end
      MODE_SET: begin
        current_frame_next = cmd.frame_number;
      end
      MODE_DIE: begin
        current_frame_next = {1'b0, cfg.normal_frames};
        life_next = (cfg.dying_frames != 8'd0) ? LIFE_DYING : LIFE_DEAD;
      end
      default: ;
    endcase
  end

  // State registers, updated once per executed command.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position    <= 16'd0;
      y_position    <= 16'd0;
      x_velocity    <= 16'd0;
      y_velocity    <= 16'd0;
      current_frame <= 9'd0;
      life          <= LIFE_ALIVE;
    end else if (exec_en) begin
      x_position    <= x_position_next;
      y_position    <= y_position_next;
      x_velocity    <= x_velocity_next;
      y_velocity    <= y_velocity_next;
      current_frame <= current_frame_next;
      life          <= life_next;
    end
  end

  // Result reflects the state after the command.
  assign res.pos_x       = x_position_next;
  assign res.pos_y       = y_position_next;
  assign res.frame_index = current_frame_next;
  assign res.life_state  = life_next;
  assign res.collided    = (mode_t'(cmd.mode) == MODE_COLLIDE) ? hit : 1'b0;

  // Place always revives the sprite at frame zero.
  a_place_revives: assert property (@(posedge clk) disable iff (rst)
    exec_en && (mode_t'(cmd.mode) == MODE_PLACE)
    |=> (life == LIFE_ALIVE) && (current_frame == 9'd0))
    else $error("place did not revive the sprite at frame zero");

  // Die without dying frames goes straight to dead.
  a_die_dead: assert property (@(posedge clk) disable iff (rst)
    exec_en && (mode_t'(cmd.mode) == MODE_DIE) && (cfg.dying_frames == 8'd0)
    |=> (life == LIFE_DEAD))
    else $error("die with no dying frames did not end dead");

  // Without an executed command the sprite state holds.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !exec_en |=> $stable(x_position) && $stable(y_position)
                 && $stable(current_frame) && $stable(life))
    else $error("sprite state changed without a command");

endmodule

// File: rtl/sprite_motion_animation_unit.sv
// ----------------------------------------------------------------------------
// Sprite motion and animation unit
// Holds one sprite's position, velocity, frame and life state and executes
// one command per transaction, returning one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on cmd_valid/cmd_stall with the mode field selecting
//   place, move, next frame, previous frame, set frame, die or collide.
//   Each command produces exactly one result on res_valid/res_stall carrying
//   position, frame, life state and the collide flag.
//   A command accepted into the command register executes once the result
//   register can take its result, which is registered there.
//   Throughput is one command per cycle while res_stall is low: each axis
//   needs three adds, a negation and two compares on registered state, and
//   the command register refills while the result register drains.
//   When res_stall is held, the result register keeps its transaction, one
//   more command waits in the command register, and then cmd_stall rises.
//   The user must write the configuration through cfg_write, cfg_index and
//   cfg_data only while no command is in flight; the block does not check.
//   Synchronous reset clears both pipeline registers, sets the sprite to
//   alive at the origin with frame zero, and loads the default viewport.
// ----------------------------------------------------------------------------
module sprite_motion_animation_unit import smau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Command channel.
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         mode,
  input  logic signed [15:0] place_x,
  input  logic signed [15:0] place_y,
  input  logic signed [15:0] step_dx,
  input  logic signed [15:0] step_dy,
  input  logic [8:0]         frame_number,
  input  logic signed [15:0] other_left,
  input  logic signed [15:0] other_top,
  input  logic signed [15:0] other_right,
  input  logic signed [15:0] other_bottom,
  input  logic               other_alive,
  // Result channel.
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic [8:0]         frame_index,
  output logic [1:0]         life_state,
  output logic               collided
);

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_q;
  logic cmd_q_valid;
  logic advance;
  logic cmd_take;
  res_t res_next;
  res_t res_q;

  smau_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Gather the command fields into one word.
  assign cmd_in.mode         = mode;
  assign cmd_in.place_x      = place_x;
  assign cmd_in.place_y      = place_y;
  assign cmd_in.step_dx      = step_dx;
  assign cmd_in.step_dy      = step_dy;
  assign cmd_in.frame_number = frame_number;
  assign cmd_in.other_left   = other_left;
  assign cmd_in.other_top    = other_top;
  assign cmd_in.other_right  = other_right;
  assign cmd_in.other_bottom = other_bottom;
  assign cmd_in.other_alive  = other_alive;

  // The held command executes when the result register can take its result.
  assign advance   = cmd_q_valid && (!res_valid || !res_stall);
  assign cmd_stall = cmd_q_valid && !advance;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_take) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd_in;
    end
  end

  smau_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .exec_en (advance),
    .cmd     (cmd_q),
    .res     (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign pos_x       = res_q.pos_x;
  assign pos_y       = res_q.pos_y;
  assign frame_index = res_q.frame_index;
  assign life_state  = res_q.life_state;
  assign collided    = res_q.collided;

  // Commands are held back only while both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> cmd_q_valid && res_valid && res_stall)
    else $error("command stalled while the pipeline could move");

  // An executed command always shows up as a result at the next edge.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("executed command produced no result transaction");

  // Reset empties both pipeline registers.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !cmd_q_valid && !res_valid)
    else $error("pipeline not empty after reset");

endmodule

// File: dv/sprite_motion_animation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite motion and animation unit testbench
// Drives command transactions through the sprite unit and compares every
// result with an in-bench prediction of position, frame, life and collision.
// Runs directed corner cases, frame sequences under several frame counts,
// random traffic under a range of viewport settings, back-pressure and streaming.
// ----------------------------------------------------------------------------
module sprite_motion_animation_unit_tb;
  import smau_pkg::*;

  // The mode code that the unit treats as a no-op.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;

  // Position and velocity of one axis after a move.
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] vel;
  } axis_motion_t;

  // Sprite state as the unit should hold it.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [8:0]  frame;
    life_t       life;
  } sprite_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [2:0]         mode = '0;
  logic signed [15:0] place_x = '0;
  logic signed [15:0] place_y = '0;
  logic signed [15:0] step_dx = '0;
  logic signed [15:0] step_dy = '0;
  logic [8:0]         frame_number = '0;
  logic signed [15:0] other_left = '0;
  logic signed [15:0] other_top = '0;
  logic signed [15:0] other_right = '0;
  logic signed [15:0] other_bottom = '0;
  logic               other_alive = 1'b0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [8:0]         frame_index;
  logic [1:0]         life_state;
  logic               collided;

  // Predicted state, register settings and results still to arrive.
  sprite_t sprite = '0;
  cfg_t    settings = {16'd0, 16'd0, 16'd320, 16'd240, 8'd16, 8'd16, 8'd1, 8'd0};
  res_t    predicted_status[$];

  int error_count = 0;
  int commands_accepted = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int idle_cycles = 0;
  int hold_request = 0;
  int stall_left = 0;
  bit tx_bursts_on = 1'b0;
  bit rx_bursts_on = 1'b0;

  sprite_motion_animation_unit DUT (.*);

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one failure line and counts it.
  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %0h, expected %0h",
                             results_checked, name, got, want));
  endtask

  // Steps one axis, then bounces off [lo, hi) for a sprite of extent ext.
  function automatic axis_motion_t bounce_axis(logic [15:0] pos, logic [15:0] vel,
                                               logic [15:0] step, logic [15:0] lo,
                                               logic [15:0] hi, logic [7:0] ext);
    logic signed [15:0] moved;
    logic signed [15:0] low_edge;
    logic signed [15:0] high_edge;
    axis_motion_t       m;
    moved     = pos + step;
    low_edge  = lo;
    high_edge = hi;
    m.pos     = moved;
    m.vel     = vel;
    if (int'(moved) + int'(ext) >= int'(high_edge) || moved < low_edge) begin
      m.vel = 16'd0 - vel;
      m.pos = moved + m.vel;
    end
    return m;
  endfunction

  // Applies one command to the predicted sprite and returns its status.
  function automatic res_t apply_command(cmd_t c);
    axis_motion_t       axis;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ol;
    logic signed [15:0] ot;
    logic signed [15:0] orr;
    logic signed [15:0] ob;
    int                 frame_after;
    res_t               r;
    r.collided = 1'b0;
    case (c.mode)
      MODE_PLACE: begin
        sprite.x     = c.place_x;
        sprite.y     = c.place_y;
        sprite.vx    = c.step_dx;
        sprite.vy    = c.step_dy;
        sprite.frame = 9'd0;
        sprite.life  = LIFE_ALIVE;
      end
      MODE_MOVE: begin
        axis = bounce_axis(sprite.x, sprite.vx, c.step_dx, settings.view_left,
                           settings.view_right, settings.sprite_width);
        sprite.x  = axis.pos;
        sprite.vx = axis.vel;
        axis = bounce_axis(sprite.y, sprite.vy, c.step_dy, settings.view_top,
                           settings.view_bottom, settings.sprite_height);
        sprite.y  = axis.pos;
        sprite.vy = axis.vel;
      end
      MODE_NEXT: begin
        frame_after = int'(sprite.frame) + 1;
        if (sprite.life == LIFE_ALIVE) begin
          if (frame_after >= int'(settings.normal_frames)) sprite.frame = 9'd0;
          else sprite.frame = 9'(frame_after);
        end else if (sprite.life == LIFE_DYING) begin
          sprite.frame = 9'(frame_after);
          if (frame_after >= int'(settings.normal_frames) + int'(settings.dying_frames))
            sprite.life = LIFE_DEAD;
        end
      end
      MODE_PREV: begin
        if (sprite.frame == 9'd0) sprite.frame = 9'(int'(settings.normal_frames) - 1);
        else sprite.frame = sprite.frame - 9'd1;
      end
      MODE_SET: sprite.frame = c.frame_number;
      MODE_DIE: begin
        sprite.frame = {1'b0, settings.normal_frames};
        if (settings.dying_frames != 8'd0) sprite.life = LIFE_DYING;
        else sprite.life = LIFE_DEAD;
      end
      MODE_COLLIDE: begin
        sx  = sprite.x;
        sy  = sprite.y;
        ol  = c.other_left;
        ot  = c.other_top;
        orr = c.other_right;
        ob  = c.other_bottom;
        r.collided = c.other_alive &&
                     (ol < int'(sx) + int'(settings.sprite_width) - Border) &&
                     (orr > int'(sx) + Border) &&
                     (ot < int'(sy) + int'(settings.sprite_height) - Border) &&
                     (ob > int'(sy) + Border);
      end
      default: ;
    endcase
    r.pos_x       = sprite.x;
    r.pos_y       = sprite.y;
    r.frame_index = sprite.frame;
    r.life_state  = sprite.life;
    return r;
  endfunction

  // Predicts each accepted command, then checks each accepted result.
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        predicted_status.push_back(apply_command({mode, place_x, place_y, step_dx,
          step_dy, frame_number, other_left, other_top, other_right, other_bottom,
          other_alive}));
        commands_accepted++;
      end
      if (res_valid && !res_stall) begin
        results_checked++;
        if (predicted_status.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected", results_checked));
        end else begin
          want = predicted_status.pop_front();
          compare_field("pos_x", pos_x, want.pos_x);
          compare_field("pos_y", pos_y, want.pos_y);
          compare_field("frame_index", 16'(frame_index), 16'(want.frame_index));
          compare_field("life_state", 16'(life_state), 16'(want.life_state));
          compare_field("collided", 16'(collided), 16'(want.collided));
        end
      end
    end
  end

  // Ends the run when no transaction has moved for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: a requested long hold, random stall bursts, or none.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left == 0 && rx_bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic sender_idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
  endtask

  // Offers one command and waits for the handshake that takes it.
  task automatic issue_command(cmd_t c);
    if (tx_bursts_on && $urandom_range(0, 5) == 0) sender_idle($urandom_range(1, 10));
    @(negedge clk);
    cmd_valid    <= 1'b1;
    mode         <= c.mode;
    place_x      <= c.place_x;
    place_y      <= c.place_y;
    step_dx      <= c.step_dx;
    step_dy      <= c.step_dy;
    frame_number <= c.frame_number;
    other_left   <= c.other_left;
    other_top    <= c.other_top;
    other_right  <= c.other_right;
    other_bottom <= c.other_bottom;
    other_alive  <= c.other_alive;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Stops offering commands until every predicted result has come back.
  task automatic wait_for_results();
    sender_idle(1);
    while (predicted_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_VIEW_LEFT:     settings.view_left = data;
      REG_VIEW_TOP:      settings.view_top = data;
      REG_VIEW_RIGHT:    settings.view_right = data;
      REG_VIEW_BOTTOM:   settings.view_bottom = data;
      REG_SPRITE_WIDTH:  settings.sprite_width = data[7:0];
      REG_SPRITE_HEIGHT: settings.sprite_height = data[7:0];
      REG_NORMAL_FRAMES: settings.normal_frames = data[7:0];
      REG_DYING_FRAMES:  settings.dying_frames = data[7:0];
      default: ;
    endcase
  endtask

  // Writes all registers; the unused upper byte of 8-bit registers is random.
  task automatic load_settings(cfg_t s);
    write_register(REG_VIEW_LEFT, s.view_left);
    write_register(REG_VIEW_TOP, s.view_top);
    write_register(REG_VIEW_RIGHT, s.view_right);
    write_register(REG_VIEW_BOTTOM, s.view_bottom);
    write_register(REG_SPRITE_WIDTH, {8'($urandom), s.sprite_width});
    write_register(REG_SPRITE_HEIGHT, {8'($urandom), s.sprite_height});
    write_register(REG_NORMAL_FRAMES, {8'($urandom), s.normal_frames});
    write_register(REG_DYING_FRAMES, {8'($urandom), s.dying_frames});
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_loaded++;
  endtask

  function automatic cfg_t make_settings(int l, int t, int r, int b, int w, int h,
                                         int nf, int df);
    cfg_t s;
    s.view_left     = 16'(l);
    s.view_top      = 16'(t);
    s.view_right    = 16'(r);
    s.view_bottom   = 16'(b);
    s.sprite_width  = 8'(w);
    s.sprite_height = 8'(h);
    s.normal_frames = 8'(nf);
    s.dying_frames  = 8'(df);
    return s;
  endfunction

  // Builds a command; the four numbers mean position and velocity for place,
  // the step for move, the frame for set frame, and the box for collide.
  function automatic cmd_t make_command(logic [2:0] m, int a = 0, int b = 0, int c = 0,
                                        int d = 0, bit alive = 1'b1);
    cmd_t k;
    k      = '0;
    k.mode = m;
    case (m)
      MODE_PLACE: begin
        k.place_x = 16'(a);
        k.place_y = 16'(b);
        k.step_dx = 16'(c);
        k.step_dy = 16'(d);
      end
      MODE_MOVE: begin
        k.step_dx = 16'(a);
        k.step_dy = 16'(b);
      end
      MODE_SET: k.frame_number = 9'(a);
      MODE_COLLIDE: begin
        k.other_left   = 16'(a);
        k.other_top    = 16'(b);
        k.other_right  = 16'(c);
        k.other_bottom = 16'(d);
        k.other_alive  = alive;
      end
      default: ;
    endcase
    return k;
  endfunction

  // Random command: mostly moves, frame steps and collisions near the sprite,
  // with every field random underneath and an occasional wild value.
  function automatic cmd_t random_command();
    cmd_t               c;
    int                 roll;
    int                 w;
    int                 h;
    int                 ol;
    int                 ot;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] vl;
    logic signed [15:0] vt;
    logic signed [15:0] vr;
    logic signed [15:0] vb;
    c.place_x      = 16'($urandom);
    c.place_y      = 16'($urandom);
    c.step_dx      = 16'($urandom);
    c.step_dy      = 16'($urandom);
    c.frame_number = 9'($urandom);
    c.other_left   = 16'($urandom);
    c.other_top    = 16'($urandom);
    c.other_right  = 16'($urandom);
    c.other_bottom = 16'($urandom);
    c.other_alive  = 1'($urandom);
    sx = sprite.x;
    sy = sprite.y;
    vl = settings.view_left;
    vt = settings.view_top;
    vr = settings.view_right;
    vb = settings.view_bottom;
    w  = int'(settings.sprite_width);
    h  = int'(settings.sprite_height);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c.mode = MODE_PLACE;
      if ($urandom_range(0, 7) != 0) begin
        if (vr > vl) c.place_x = 16'(int'(vl) + int'($urandom_range(0, int'(vr) - int'(vl))));
        if (vb > vt) c.place_y = 16'(int'(vt) + int'($urandom_range(0, int'(vb) - int'(vt))));
        c.step_dx = 16'(int'($urandom_range(0, 16)) - 8);
        c.step_dy = 16'(int'($urandom_range(0, 16)) - 8);
      end
    end else if (roll < 43) begin
      c.mode = MODE_MOVE;
      if ($urandom_range(0, 9) != 0) begin
        c.step_dx = 16'(int'($urandom_range(0, 40)) - 20);
        c.step_dy = 16'(int'($urandom_range(0, 40)) - 20);
      end
    end else if (roll < 58) begin
      c.mode = MODE_NEXT;
    end else if (roll < 66) begin
      c.mode = MODE_PREV;
    end else if (roll < 72) begin
      c.mode = MODE_SET;
      if ($urandom_range(0, 3) != 0)
        c.frame_number = 9'($urandom_range(0, int'(settings.normal_frames) +
                                              int'(settings.dying_frames) + 1));
    end else if (roll < 77) begin
      c.mode = MODE_DIE;
    end else if (roll < 97) begin
      c.mode = MODE_COLLIDE;
      if ($urandom_range(0, 9) != 0) begin
        ol = int'(sx) + int'($urandom_range(0, 2 * w + 40)) - (w + 20);
        ot = int'(sy) + int'($urandom_range(0, 2 * h + 40)) - (h + 20);
        c.other_left   = 16'(ol);
        c.other_right  = 16'(ol + int'($urandom_range(0, 40)));
        c.other_top    = 16'(ot);
        c.other_bottom = 16'(ot + int'($urandom_range(0, 40)));
        c.other_alive  = ($urandom_range(0, 4) != 0);
      end
    end else begin
      c.mode = MODE_UNUSED;
    end
    return c;
  endfunction

  // Corner cases under the reset register values.
  task automatic test_directed_commands();
    issue_command(make_command(MODE_UNUSED));
    issue_command(make_command(MODE_COLLIDE, -5, -5, 5, 5));
    issue_command(make_command(MODE_PLACE, 100, 50, 3, -2));
    issue_command(make_command(MODE_MOVE, 5, 5));
    // Right edge bounce, then left and top edge bounce together.
    issue_command(make_command(MODE_MOVE, 300, 0));
    issue_command(make_command(MODE_MOVE, -500, -100));
    // Field extremes and position wrap-around.
    issue_command(make_command(MODE_PLACE, 32767, -32768, 32767, -32768));
    issue_command(make_command(MODE_MOVE, 1, -1));
    issue_command(make_command(MODE_MOVE, -32768, 32767));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_SET, 511));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_SET, 300));
    issue_command(make_command(MODE_PREV));
    issue_command(make_command(MODE_SET, 0));
    issue_command(make_command(MODE_PREV));
    // Without dying frames the sprite goes straight to dead.
    issue_command(make_command(MODE_DIE));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_PREV));
    issue_command(make_command(MODE_COLLIDE, -32768, -32768, 32767, 32767, 1'b0));
    // Touching edges do not count as overlap.
    issue_command(make_command(MODE_PLACE, 10, 10, 0, 0));
    issue_command(make_command(MODE_COLLIDE, 26, 10, 40, 20));
    issue_command(make_command(MODE_COLLIDE, 25, 25, 40, 40));
    issue_command(make_command(MODE_COLLIDE, -32768, -32768, 32767, 32767));
    issue_command(make_command(MODE_COLLIDE, 32767, 32767, -32768, -32768));
  endtask

  // Animation through normal, dying and dead frames, including zero and
  // maximum frame counts and a frame loaded past the end.
  task automatic test_frame_animation();
    wait_for_results();
    load_settings(make_settings(0, 0, 320, 240, 16, 16, 4, 3));
    issue_command(make_command(MODE_PLACE, 40, 40, 1, 1));
    repeat (5) issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_DIE));
    repeat (4) issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_PREV));
    issue_command(make_command(MODE_PLACE, 40, 40, 1, 1));
    issue_command(make_command(MODE_SET, 200));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_DIE));
    issue_command(make_command(MODE_SET, 300));
    issue_command(make_command(MODE_NEXT));
    wait_for_results();
    load_settings(make_settings(0, 0, 320, 240, 16, 16, 0, 0));
    issue_command(make_command(MODE_PLACE, 40, 40, 1, 1));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_PREV));
    issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_DIE));
    wait_for_results();
    load_settings(make_settings(0, 0, 320, 240, 16, 16, 255, 255));
    issue_command(make_command(MODE_PLACE, 40, 40, 1, 1));
    issue_command(make_command(MODE_DIE));
    issue_command(make_command(MODE_SET, 508));
    repeat (2) issue_command(make_command(MODE_NEXT));
    issue_command(make_command(MODE_PLACE, 40, 40, 1, 1));
    issue_command(make_command(MODE_DIE));
    issue_command(make_command(MODE_SET, 511));
    issue_command(make_command(MODE_NEXT));
  endtask

  // Random traffic under four fixed settings, three of them extreme, and two random viewports.
  task automatic test_random_traffic();
    cfg_t phase_settings[6];
    int   l;
    int   t;
    phase_settings[0] = make_settings(0, 0, 320, 240, 16, 16, 4, 3);
    phase_settings[1] = make_settings(-32768, -32768, 32767, 32767, 255, 255, 255, 255);
    phase_settings[2] = make_settings(100, -50, 140, -10, 0, 0, 1, 0);
    // Inverted viewport: every move bounces on both axes.
    phase_settings[3] = make_settings(200, 150, -200, -150, 8, 8, 0, 1);
    for (int i = 4; i < 6; i++) begin
      l = int'($urandom_range(0, 2000)) - 1000;
      t = int'($urandom_range(0, 2000)) - 1000;
      phase_settings[i] = make_settings(l, t, l + int'($urandom_range(20, 600)),
                                        t + int'($urandom_range(20, 600)),
                                        $urandom_range(0, 64), $urandom_range(0, 64),
                                        $urandom_range(1, 20), $urandom_range(0, 10));
    end
    foreach (phase_settings[i]) begin
      wait_for_results();
      load_settings(phase_settings[i]);
      repeat (150) issue_command(random_command());
    end
  endtask

  // The receiver holds off while commands keep coming, so the unit fills up
  // and stalls its input; after a full drain, both sides pause in random bursts.
  task automatic test_backpressure();
    wait_for_results();
    tx_bursts_on = 1'b0;
    rx_bursts_on = 1'b0;
    hold_request = 60;
    repeat (16) issue_command(random_command());
    wait_for_results();
    tx_bursts_on = 1'b1;
    rx_bursts_on = 1'b1;
    repeat (30) issue_command(random_command());
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_streaming_tail();
    wait_for_results();
    tx_bursts_on = 1'b0;
    rx_bursts_on = 1'b0;
    repeat (120) issue_command(random_command());
  endtask

  // Test sequence.
  initial begin
    tx_bursts_on = 1'b1;
    rx_bursts_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_frame_animation();
    test_random_traffic();
    test_backpressure();
    test_streaming_tail();
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Ran %0d commands and checked %0d results over %0d register settings,",
             commands_accepted, results_checked, settings_loaded);
    $display("covering viewport, size and frame count extremes, idling and back-pressure.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sprite_motion_animation_unit.f
rtl/smau_pkg.sv
rtl/smau_cfg_regs.sv
rtl/smau_core.sv
rtl/sprite_motion_animation_unit.sv
dv/sprite_motion_animation_unit_tb.sv
